>>> rtl/srt_pkg.sv
`default_nettype none
package srt_pkg;
    localparam int JobSlotsDefault = 16;
    localparam int TimeBitsDefault = 32;

    localparam logic [1:0] StatusAccepted = 2'd0;
    localparam logic [1:0] StatusDropped = 2'd1;
    localparam logic [1:0] StatusRan = 2'd2;
    localparam logic [1:0] StatusIdle = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic scan_clear;
        logic scan_step;
        logic do_arrival;
        logic do_tick;
    } srt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } srt_stat_t;
endpackage
`default_nettype wire

>>> rtl/shortest_remaining_time_scheduler.sv
// Preemptive shortest-remaining-time-first scheduler with JOB_SLOTS ready slots.
// An item is taken only while the block is idle. An item passes through the
// scan, execute and result states; an arrival leaves the scan without walking the
// slots, while a tick's scan walks every slot through one shared comparator. One result follows each item.
`default_nettype none
module shortest_remaining_time_scheduler
    import srt_pkg::*;
#(
    parameter int JOB_SLOTS = JobSlotsDefault,
    parameter int TIME_BITS = TimeBitsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  job_id,
    input  wire logic [15:0] burst_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [7:0]       running_id,
    output logic             finished,
    output logic [31:0]      wait_units,
    output logic [31:0]      turnaround_units,
    output logic [31:0]      time_now
);
    srt_cmd_t  cmd;
    srt_stat_t stat;

    srt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_func(func), .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat)
    );

    srt_datapath #(.JOB_SLOTS(JOB_SLOTS), .TIME_BITS(TIME_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_take(in_valid && !in_stall),
        .job_id(job_id), .burst_length(burst_length), .cmd(cmd), .stat(stat),
        .status(status), .running_id(running_id), .finished(finished),
        .wait_units(wait_units), .turnaround_units(turnaround_units),
        .time_now(time_now)
    );
endmodule
`default_nettype wire

>>> rtl/srt_ctrl.sv
`default_nettype none
module srt_ctrl
    import srt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic in_func,
    output logic      out_valid,
    input  wire logic out_stall,
    output srt_cmd_t  cmd,
    input  srt_stat_t stat
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   func_reg;

    // The input is taken only when no item is in flight.
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last || !func_reg)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.do_arrival = !func_reg;
                cmd.do_tick = func_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and latched function code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            func_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && in_valid)
            begin
                func_reg <= in_func;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/srt_datapath.sv
`default_nettype none
module srt_datapath
    import srt_pkg::*;
#(
    parameter int JOB_SLOTS = JobSlotsDefault,
    parameter int TIME_BITS = TimeBitsDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_take,
    input  wire logic [7:0]  job_id,
    input  wire logic [15:0] burst_length,
    input  srt_cmd_t         cmd,
    output srt_stat_t        stat,
    output logic [1:0]       status,
    output logic [7:0]       running_id,
    output logic             finished,
    output logic [31:0]      wait_units,
    output logic [31:0]      turnaround_units,
    output logic [31:0]      time_now
);
    localparam int SW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam logic [SW-1:0] LastSlot = SW'(JOB_SLOTS - 1);

    logic [JOB_SLOTS-1:0] valid_reg;
    logic [7:0]           id_reg [JOB_SLOTS];
    logic [TIME_BITS-1:0] arr_reg [JOB_SLOTS];
    logic [15:0]          rem_reg [JOB_SLOTS];
    logic [15:0]          tot_reg [JOB_SLOTS];
    logic                 act_valid_reg;
    logic [SW-1:0]        act_slot_reg;
    logic [TIME_BITS-1:0] clock_reg;
    logic [7:0]           in_id_reg;
    logic [15:0]          in_burst_reg;
    logic [SW-1:0]        idx_reg;
    logic                 have_reg;
    logic [SW-1:0]        best_reg;

    // Strict order: remaining time, then arrival, then id.
    function automatic logic better(input logic [15:0] ra, input logic [TIME_BITS-1:0] aa,
                                    input logic [7:0] ia, input logic [15:0] rb,
                                    input logic [TIME_BITS-1:0] ab, input logic [7:0] ib);
        if (ra != rb) return ra < rb;
        if (aa != ab) return aa < ab;
        return ia < ib;
    endfunction

    logic cand_ok, cand_better, best_beats_act, take_best;
    logic free_found;
    logic [SW-1:0] free_slot;
    logic [TIME_BITS-1:0] clock_inc, turn_full, wait_full;
    logic [SW-1:0] run_slot;
    logic [15:0] rem_dec;

    assign stat.scan_last = (idx_reg == LastSlot);
    assign cand_ok = valid_reg[idx_reg] && !(act_valid_reg && idx_reg == act_slot_reg);
    assign cand_better = better(rem_reg[idx_reg], arr_reg[idx_reg], id_reg[idx_reg],
                                rem_reg[best_reg], arr_reg[best_reg], id_reg[best_reg]);
    assign best_beats_act = better(rem_reg[best_reg], arr_reg[best_reg], id_reg[best_reg],
                                   rem_reg[act_slot_reg], arr_reg[act_slot_reg],
                                   id_reg[act_slot_reg]);
    assign take_best = have_reg && (!act_valid_reg || best_beats_act);
    assign run_slot = take_best ? best_reg : act_slot_reg;
    assign clock_inc = clock_reg + 1'b1;
    assign rem_dec = (rem_reg[run_slot] != 16'd0) ? rem_reg[run_slot] - 16'd1 : 16'd0;
    assign turn_full = clock_inc - arr_reg[run_slot];
    assign wait_full = turn_full - TIME_BITS'(tot_reg[run_slot]);

    // Lowest free slot, narrow priority pick.
    always_comb
    begin
        free_found = 1'b0;
        free_slot = '0;
        for (int i = JOB_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    // Slot payload storage.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_id_reg <= job_id;
            in_burst_reg <= burst_length;
        end
        if (cmd.do_arrival && free_found)
        begin
            id_reg[free_slot] <= in_id_reg;
            arr_reg[free_slot] <= clock_reg;
            rem_reg[free_slot] <= in_burst_reg;
            tot_reg[free_slot] <= in_burst_reg;
        end
        if (cmd.do_tick && (take_best || act_valid_reg))
        begin
            rem_reg[run_slot] <= rem_dec;
        end
    end

    // Control state, scan and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            act_valid_reg <= 1'b0;
            act_slot_reg <= '0;
            clock_reg <= '0;
            idx_reg <= '0;
            have_reg <= 1'b0;
            best_reg <= '0;
            status <= StatusAccepted;
            running_id <= '0;
            finished <= 1'b0;
            wait_units <= '0;
            turnaround_units <= '0;
            time_now <= '0;
        end
        else
        begin
            if (cmd.scan_clear)
            begin
                idx_reg <= '0;
                have_reg <= 1'b0;
                best_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                if (cand_ok && (!have_reg || cand_better))
                begin
                    best_reg <= idx_reg;
                    have_reg <= 1'b1;
                end
                if (!stat.scan_last)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (cmd.do_arrival)
            begin
                running_id <= '0;
                finished <= 1'b0;
                wait_units <= '0;
                turnaround_units <= '0;
                time_now <= 32'(clock_reg);
                if (free_found)
                begin
                    valid_reg[free_slot] <= 1'b1;
                    status <= StatusAccepted;
                end
                else
                begin
                    status <= StatusDropped;
                end
            end
            if (cmd.do_tick)
            begin
                clock_reg <= clock_inc;
                time_now <= 32'(clock_inc);
                finished <= 1'b0;
                wait_units <= '0;
                turnaround_units <= '0;
                if (take_best || act_valid_reg)
                begin
                    status <= StatusRan;
                    running_id <= id_reg[run_slot];
                    act_slot_reg <= run_slot;
                    act_valid_reg <= 1'b1;
                    if (rem_dec == 16'd0)
                    begin
                        finished <= 1'b1;
                        turnaround_units <= 32'(turn_full);
                        wait_units <= 32'(wait_full);
                        valid_reg[run_slot] <= 1'b0;
                        act_valid_reg <= 1'b0;
                    end
                end
                else
                begin
                    status <= StatusIdle;
                    running_id <= '0;
                    act_valid_reg <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/srt_checker.sv
`default_nettype none
module srt_checker
    import srt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [1:0]  status,
    input wire logic        finished,
    input wire logic [31:0] wait_units,
    input wire logic [31:0] turnaround_units
);
    // A transfer in is never followed at once by a result.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result in cycle after input transfer");

    // Only a tick that ran a job can finish.
    a_fin_ran: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (status == StatusRan))
        else $error("finish without run");

    // A result that does not finish a job reports zero times.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !finished) |-> (wait_units == 32'd0 && turnaround_units == 32'd0))
        else $error("nonzero times without finish");

    // No input is taken while a result is pending.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    // A stalled result stays offered and does not change.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(finished)
            && $stable(wait_units) && $stable(turnaround_units)))
        else $error("stalled result changed");
endmodule

bind shortest_remaining_time_scheduler srt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .finished(finished), .wait_units(wait_units), .turnaround_units(turnaround_units)
);
`default_nettype wire
